// File: hdl/vlsp_pkg.sv
// ============================================================================
// vlsp_pkg - shared types and constants for the vertex layout string parser
// Character codes, status and usage codes, parser state and result record.
// ============================================================================
package vlsp_pkg;

    localparam int MAX_ELEMENTS = 32;

    // characters of the layout text
    localparam logic [7:0] CH_END   = 8'h00;
    localparam logic [7:0] CH_ALIGN = 8'h7C; // '|'
    localparam logic [7:0] CH_PAD   = 8'h78; // 'x'
    localparam logic [7:0] CH_FLOAT = 8'h66; // 'f'
    localparam logic [7:0] CH_BYTE  = 8'h62; // 'b'
    localparam logic [7:0] CH_ONE   = 8'h31; // '1'
    localparam logic [7:0] CH_THREE = 8'h33; // '3'
    localparam logic [7:0] CH_FOUR  = 8'h34; // '4'

    // status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_SHORT     = 4'd1;
    localparam logic [3:0] ST_BAD_USAGE = 4'd2;
    localparam logic [3:0] ST_BAD_MULT  = 4'd3;
    localparam logic [3:0] ST_COMBO     = 4'd4;
    localparam logic [3:0] ST_BAD_TYPE  = 4'd5;
    localparam logic [3:0] ST_EMPTY     = 4'd6;
    localparam logic [3:0] ST_TOO_BIG   = 4'd7;
    localparam logic [3:0] ST_TOO_MANY  = 4'd8;

    // record kinds
    localparam logic KIND_ELEM  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    // usage codes beyond the visible ones
    localparam logic [3:0] USAGE_PAD  = 4'd14;
    localparam logic [3:0] USAGE_NONE = 4'd15;

    localparam logic [2:0] TY_BYTE4 = 3'd4;

    localparam logic [8:0] OFFSET_MAX = 9'd511;
    localparam logic [9:0] SIZE_MAX   = 10'd255;
    localparam logic [9:0] ALIGN_ADD  = 10'd31;

    localparam logic [1:0] PH_USAGE = 2'd0;
    localparam logic [1:0] PH_TYPE  = 2'd1;

    typedef struct packed {
        logic [1:0] group_phase;
        logic [7:0] held_usage_char;
        logic [7:0] held_type_char;
        logic [8:0] running_offset;
        logic [5:0] element_total;
        logic       align_wanted;
        logic       at_text_start;
        logic       skipping_after_error;
    } state_t;

    localparam state_t STATE_RESET = '{
        group_phase:          PH_USAGE,
        held_usage_char:      8'h00,
        held_type_char:       8'h00,
        running_offset:       9'd0,
        element_total:        6'd0,
        align_wanted:         1'b0,
        at_text_start:        1'b1,
        skipping_after_error: 1'b0
    };

    typedef struct packed {
        logic       valid;
        logic       kind;
        logic [3:0] status;
        logic [4:0] elem_index;
        logic [8:0] elem_offset;
        logic [2:0] elem_type;
        logic [3:0] elem_usage;
        logic [5:0] elem_count;
        logic [7:0] vertex_size;
    } rec_t;

    function automatic logic [3:0] usage_code(input logic [7:0] c);
        logic [3:0] u;
        case (c)
            8'h70:   u = 4'd0; // 'p'
            8'h63:   u = 4'd1; // 'c'
            8'h6E:   u = 4'd2; // 'n'
            8'h74:   u = 4'd3; // 't'
            8'h77:   u = 4'd4; // 'w'
            8'h69:   u = 4'd5; // 'i'
            8'h30:   u = 4'd6; // '0'
            8'h31:   u = 4'd7;
            8'h32:   u = 4'd8;
            8'h33:   u = 4'd9;
            CH_PAD:  u = USAGE_PAD;
            default: u = USAGE_NONE;
        endcase
        return u;
    endfunction

endpackage

// File: hdl/vertex_layout_string_parser.sv
// ============================================================================
// vertex_layout_string_parser - vertex layout text parser, top level
// Input register, single-pass parse step and output register.
// ============================================================================
// Takes one character of a vertex layout text per beat (0 ends a text) and
// returns element records and one final status record per text. Throughput is
// one character per clock unless the output stalls: each character passes
// through the combinational parse logic between the input register and the
// output register, and its result beat is written to the output register
// when the character advances out of the input register. The input side keeps
// accepting while a finished record waits on the output side; it stalls only
// when a character that yields a record meets a full, unread output register.
// After an error the rest of the text up to the terminator is consumed
// without output.
module vertex_layout_string_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] status, [8:4] elem_index, [17:9] elem_offset, [20:18] elem_type,
    // [24:21] elem_usage, [30:25] elem_count, [38:31] vertex_size, [39] zero
    output logic [39:0] m_tdata,
    output logic        m_tuser    // [0] record_kind
);
    import vlsp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_ch_reg;
    state_t     state_reg, state_next;
    rec_t       step_rec;
    logic       out_valid_reg, out_valid_next;
    logic [38:0] out_data_reg;
    logic       out_kind_reg;
    logic       advance;

    vlsp_step u_step
    (
        .cur (state_reg),
        .ch  (in_ch_reg),
        .nxt (state_next),
        .rec (step_rec)
    );

    // held character moves on unless its record has nowhere to go
    assign advance  = in_valid_reg && (!step_rec.valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;
        out_valid_next = out_valid_reg;
        if (advance && step_rec.valid)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_ch_reg <= s_tdata;
        if (advance && step_rec.valid)
        begin
            out_kind_reg <= step_rec.kind;
            out_data_reg <= {step_rec.vertex_size, step_rec.elem_count,
                             step_rec.elem_usage, step_rec.elem_type,
                             step_rec.elem_offset, step_rec.elem_index,
                             step_rec.status};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_data_reg};
    assign m_tuser  = out_kind_reg;

    // element records always carry an ok status
    a_elem_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ELEM) |-> (m_tdata[3:0] == ST_OK))
        else $error("element record with non-ok status");

    // nothing is emitted while skipping the rest of a bad text
    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && state_reg.skipping_after_error) |-> !step_rec.valid)
        else $error("record produced while skipping");

    // a final record leaves no elements counted
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step_rec.valid && step_rec.kind == KIND_FINAL)
        |=> (state_reg.element_total == 6'd0 && state_reg.running_offset == 9'd0))
        else $error("text state not cleared after final record");

    // element count never passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.element_total <= 6'(MAX_ELEMENTS))
        else $error("element count beyond limit");

    // a record that cannot be stored holds the character back
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && step_rec.valid && m_tvalid && !m_tready) |-> !s_tready)
        else $error("record would be dropped");

endmodule

// File: hdl/vlsp_step.sv
// ============================================================================
// vlsp_step - per-character parse step
// Combinational next state and optional result record for one character.
// ============================================================================
module vlsp_step
(
    input  vlsp_pkg::state_t cur,
    input  logic [7:0]       ch,
    output vlsp_pkg::state_t nxt,
    output vlsp_pkg::rec_t   rec
);
    import vlsp_pkg::*;

    logic [9:0] size_al;
    logic [3:0] us;
    logic [2:0] ty;
    logic [4:0] el_size;
    logic [9:0] ofs_sum;
    logic [8:0] ofs_sat;
    logic [3:0] grp_status;

    // group check: usage, then type, then multiplier, then element room
    always_comb
    begin
        us         = usage_code(cur.held_usage_char);
        ty         = 3'd0;
        el_size    = 5'd0;
        grp_status = ST_OK;
        if (us == USAGE_NONE)
        begin
            grp_status = ST_BAD_USAGE;
        end
        else if (cur.held_type_char == CH_FLOAT)
        begin
            if (ch inside {[CH_ONE:CH_FOUR]})
            begin
                ty      = 3'(ch - CH_ONE);
                el_size = {ty, 2'b00} + 5'd4;
            end
            else
            begin
                grp_status = ST_BAD_MULT;
            end
        end
        else if (cur.held_type_char == CH_BYTE)
        begin
            if (ch inside {[CH_ONE:CH_THREE]})
                grp_status = ST_COMBO;
            else if (ch != CH_FOUR)
                grp_status = ST_BAD_MULT;
            else
            begin
                ty      = TY_BYTE4;
                el_size = 5'd4;
            end
        end
        else
        begin
            grp_status = ST_BAD_TYPE;
        end
        if (grp_status == ST_OK && us != USAGE_PAD
            && cur.element_total >= 6'(MAX_ELEMENTS))
            grp_status = ST_TOO_MANY;
    end

    assign ofs_sum = 10'(cur.running_offset) + 10'(el_size);
    assign ofs_sat = (ofs_sum > 10'(OFFSET_MAX)) ? OFFSET_MAX : ofs_sum[8:0];
    assign size_al = cur.align_wanted
                   ? ((10'(cur.running_offset) + ALIGN_ADD) & ~ALIGN_ADD)
                   : 10'(cur.running_offset);

    always_comb
    begin
        nxt = cur;
        rec = '0;
        if (cur.skipping_after_error)
        begin
            if (ch == CH_END)
                nxt = STATE_RESET;
        end
        else if (ch == CH_END)
        begin
            rec.valid = 1'b1;
            rec.kind  = KIND_FINAL;
            nxt       = STATE_RESET;
            if (cur.group_phase != PH_USAGE)
                rec.status = ST_SHORT;
            else if (size_al == 10'd0)
                rec.status = ST_EMPTY;
            else if (size_al > SIZE_MAX)
                rec.status = ST_TOO_BIG;
            else
            begin
                rec.status      = ST_OK;
                rec.elem_count  = cur.element_total;
                rec.vertex_size = size_al[7:0];
            end
        end
        else if (cur.at_text_start && ch == CH_ALIGN)
        begin
            nxt.at_text_start = 1'b0;
            nxt.align_wanted  = 1'b1;
        end
        else
        begin
            nxt.at_text_start = 1'b0;
            case (cur.group_phase)
                PH_USAGE:
                begin
                    nxt.held_usage_char = ch;
                    nxt.group_phase     = PH_TYPE;
                end
                PH_TYPE:
                begin
                    nxt.held_type_char = ch;
                    nxt.group_phase    = 2'd2;
                end
                default:
                begin
                    nxt.group_phase = PH_USAGE;
                    if (grp_status != ST_OK)
                    begin
                        rec.valid                = 1'b1;
                        rec.kind                 = KIND_FINAL;
                        rec.status               = grp_status;
                        nxt                      = STATE_RESET;
                        nxt.skipping_after_error = 1'b1;
                        nxt.at_text_start        = 1'b0;
                    end
                    else
                    begin
                        nxt.running_offset = ofs_sat;
                        if (us != USAGE_PAD)
                        begin
                            rec.valid         = 1'b1;
                            rec.kind          = KIND_ELEM;
                            rec.status        = ST_OK;
                            rec.elem_index    = cur.element_total[4:0];
                            rec.elem_offset   = cur.running_offset;
                            rec.elem_type     = ty;
                            rec.elem_usage    = us;
                            nxt.element_total = cur.element_total + 6'd1;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// File: tb/tb.sv
// ============================================================================
// tb - testbench for the vertex layout string parser
// Feeds layout texts one character per beat, predicts every element and
// status record in step with each accepted character, and compares each
// output beat field by field. Directed texts first, then random layouts.
// ============================================================================
`timescale 1ns / 100ps

module tb;
    import vlsp_pkg::*;

    localparam logic [1:0] PH_MULT = 2'd2;

    typedef logic [7:0] char_q_t[$];

    // one output record, unpacked
    typedef struct packed {
        logic       kind;
        logic [3:0] status;
        logic [4:0] idx;
        logic [8:0] ofs;
        logic [2:0] ty;
        logic [3:0] usage;
        logic [5:0] count;
        logic [7:0] size;
    } layout_rec_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;

    // usage letters in code order, padding last
    string usage_letters = "pcntwi0123x";
    // characters close to the legal ones, for corrupting groups
    string near_miss = "0123456789bfx|pq";

    // parser state as predicted
    logic [1:0] p_phase;
    logic [7:0] p_use_ch;
    logic [7:0] p_type_ch;
    logic [8:0] p_offset;
    logic [5:0] p_total;
    logic       p_align;
    logic       p_at_start;
    logic       p_skipping;

    layout_rec_t expected_recs[$];

    int   failures;
    int   chars_sent;
    int   texts_sent;
    int   elem_recs;
    int   final_recs;
    logic [8:0] status_seen;
    bit   in_idle_on;
    bit   out_idle_on;

    vertex_layout_string_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [3:0] usage_of(input logic [7:0] c);
        for (int i = 0; i < 10; i++)
            if (c == usage_letters[i])
                return 4'(i);
        if (c == CH_PAD)
            return USAGE_PAD;
        return USAGE_NONE;
    endfunction

    task automatic clear_text();
        p_phase    = PH_USAGE;
        p_use_ch   = 8'h00;
        p_type_ch  = 8'h00;
        p_offset   = 9'd0;
        p_total    = 6'd0;
        p_align    = 1'b0;
        p_at_start = 1'b1;
        p_skipping = 1'b0;
    endtask

    task automatic push_rec(input layout_rec_t r);
        expected_recs.push_back(r);
        if (r.kind == KIND_FINAL)
        begin
            final_recs++;
            status_seen[r.status] = 1'b1;
        end
        else
            elem_recs++;
    endtask

    // error in the middle of a text: status record now, rest skipped
    task automatic abort_text(input logic [3:0] st);
        layout_rec_t r;
        r        = '0;
        r.kind   = KIND_FINAL;
        r.status = st;
        push_rec(r);
        clear_text();
        p_skipping = 1'b1;
        p_at_start = 1'b0;
    endtask

    task automatic parse_char(input logic [7:0] c);
        layout_rec_t r;
        logic [3:0]  us;
        logic [2:0]  ty;
        logic [4:0]  sz;
        logic [9:0]  total_size;
        logic [9:0]  grown;
        r = '0;
        if (p_skipping)
        begin
            if (c == CH_END)
                clear_text();
            return;
        end
        if (c == CH_END)
        begin
            total_size = {1'b0, p_offset};
            if (p_align)
                total_size = (total_size + ALIGN_ADD) & ~ALIGN_ADD;
            r.kind = KIND_FINAL;
            if (p_phase != PH_USAGE)
                r.status = ST_SHORT;
            else if (total_size == 10'd0)
                r.status = ST_EMPTY;
            else if (total_size > SIZE_MAX)
                r.status = ST_TOO_BIG;
            else
            begin
                r.status = ST_OK;
                r.count  = p_total;
                r.size   = total_size[7:0];
            end
            push_rec(r);
            clear_text();
            return;
        end
        if (p_at_start)
        begin
            p_at_start = 1'b0;
            if (c == CH_ALIGN)
            begin
                p_align = 1'b1;
                return;
            end
        end
        if (p_phase == PH_USAGE)
        begin
            p_use_ch = c;
            p_phase  = PH_TYPE;
            return;
        end
        if (p_phase == PH_TYPE)
        begin
            p_type_ch = c;
            p_phase   = PH_MULT;
            return;
        end

        // third character: usage, then type, then multiplier, then element room
        p_phase = PH_USAGE;
        us = usage_of(p_use_ch);
        if (us == USAGE_NONE)
        begin
            abort_text(ST_BAD_USAGE);
            return;
        end
        if (p_type_ch == CH_FLOAT)
        begin
            if (c >= CH_ONE && c <= CH_FOUR)
            begin
                ty = 3'(c - CH_ONE);
                sz = 5'(4 * (ty + 1));
            end
            else
            begin
                abort_text(ST_BAD_MULT);
                return;
            end
        end
        else if (p_type_ch == CH_BYTE)
        begin
            if (c >= CH_ONE && c <= CH_THREE)
            begin
                abort_text(ST_COMBO);
                return;
            end
            if (c != CH_FOUR)
            begin
                abort_text(ST_BAD_MULT);
                return;
            end
            ty = TY_BYTE4;
            sz = 5'd4;
        end
        else
        begin
            abort_text(ST_BAD_TYPE);
            return;
        end

        if (us != USAGE_PAD)
        begin
            if (p_total >= MAX_ELEMENTS)
            begin
                abort_text(ST_TOO_MANY);
                return;
            end
            r.kind   = KIND_ELEM;
            r.status = ST_OK;
            r.idx    = p_total[4:0];
            r.ofs    = p_offset;
            r.ty     = ty;
            r.usage  = us;
            push_rec(r);
            p_total  = p_total + 6'd1;
        end
        grown    = {1'b0, p_offset} + 10'(sz);
        p_offset = (grown > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : grown[8:0];
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        layout_rec_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_recs.size() == 0)
            begin
                $error("result beat with nothing expected: tdata %h tuser %b",
                       m_tdata, m_tuser);
                failures++;
            end
            else
            begin
                want = expected_recs.pop_front();
                check_field("record_kind", want.kind,   m_tuser);
                check_field("status",      want.status, m_tdata[3:0]);
                check_field("elem_index",  want.idx,    m_tdata[8:4]);
                check_field("elem_offset", want.ofs,    m_tdata[17:9]);
                check_field("elem_type",   want.ty,     m_tdata[20:18]);
                check_field("elem_usage",  want.usage,  m_tdata[24:21]);
                check_field("elem_count",  want.count,  m_tdata[30:25]);
                check_field("vertex_size", want.size,   m_tdata[38:31]);
                check_field("tdata pad",   0,           m_tdata[39]);
            end
        end
    end

    // receiver: random stall before each beat, with calm stretches
    initial
    begin
        int stall;
        m_tready = 1'b0;
        out_idle_on = 1'b1;
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                out_idle_on = !out_idle_on;
            stall = out_idle_on ? $urandom_range(0, 11) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // called and returns at a falling edge; valid stays high across
    // back-to-back beats
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = in_idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge clk); while (!s_tready);
        parse_char(c);
        chars_sent++;
        if (c == CH_END)
            texts_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input char_q_t t);
        foreach (t[i])
            send_char(t[i]);
    endtask

    task automatic send_layout(input string body);
        for (int i = 0; i < body.len(); i++)
            send_char(8'(body[i]));
        send_char(CH_END);
    endtask

    function automatic void add_groups(ref char_q_t t, input string g, input int n);
        repeat (n)
            for (int i = 0; i < g.len(); i++)
                t.push_back(8'(g[i]));
    endfunction

    // hold the input off until every predicted record has come out
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_recs.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_empty_texts();
        send_char(CH_END);      // nothing at all
        send_layout("|");       // alignment mark alone
    endtask

    task automatic test_alignment();
        send_layout("pf3");     // 12 bytes, no rounding
        send_layout("|pf4xb4"); // 20 bytes rounded up to 32
        send_layout("||f1");    // second mark is read as a usage
    endtask

    task automatic test_group_errors();
        send_layout("cb2");     // byte vector of fewer than four
        send_layout("nq3");     // unknown type
        send_char("0");         // bad multiplier, top code
        send_char(CH_FLOAT);
        send_char(8'hFF);
        send_char(CH_END);
        send_layout("3f");      // text ends inside a group
    endtask

    task automatic test_element_limits();
        char_q_t t;
        t = {};
        add_groups(t, "pf1", MAX_ELEMENTS);     // full table, count 32
        t.push_back(CH_END);
        add_groups(t, "cf1", MAX_ELEMENTS + 1); // one too many
        t.push_back(CH_END);
        add_groups(t, "xf4", 32);               // padding saturates offset
        add_groups(t, "2b4", 1);                // element at offset 511
        t.push_back(CH_END);
        add_groups(t, "tf4", 16);               // 256 bytes
        t.push_back(CH_END);
        send_text(t);
    endtask

    task automatic test_random_layouts();
        char_q_t t;
        int      shape;
        int      n;
        int      pos;
        while (chars_sent < 1500)
        begin
            t = {};
            in_idle_on = ($urandom_range(0, 3) != 0);
            shape = $urandom_range(0, 19);
            if (shape == 19)
            begin
                // plain noise
                repeat ($urandom_range(1, 10))
                    t.push_back(8'($urandom_range(1, 255)));
            end
            else
            begin
                if ($urandom_range(0, 1))
                    t.push_back(CH_ALIGN);
                n = (shape < 3) ? $urandom_range(9, 40) : $urandom_range(0, 6);
                repeat (n)
                begin
                    t.push_back(8'(usage_letters[$urandom_range(0, 10)]));
                    if ($urandom_range(0, 3) == 0)
                    begin
                        t.push_back(CH_BYTE);
                        t.push_back(CH_FOUR);
                    end
                    else
                    begin
                        t.push_back(CH_FLOAT);
                        t.push_back(8'($urandom_range(CH_ONE, CH_FOUR)));
                    end
                end
                if (shape >= 15 && shape <= 17 && t.size() > 0)
                begin
                    // corrupt one character, half the time with a near miss
                    pos = $urandom_range(0, t.size() - 1);
                    if ($urandom_range(0, 1))
                        t[pos] = 8'(near_miss[$urandom_range(0, near_miss.len() - 1)]);
                    else
                        t[pos] = 8'($urandom_range(1, 255));
                    // garbage after the fault gets skipped
                    repeat ($urandom_range(0, 4))
                        t.push_back(8'($urandom_range(1, 255)));
                end
                else if (shape == 18 && t.size() > 0)
                    void'(t.pop_back());
            end
            t.push_back(CH_END);
            send_text(t);
            if (shape == 4)
                wait_all_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        failures    = 0;
        chars_sent  = 0;
        texts_sent  = 0;
        elem_recs   = 0;
        final_recs  = 0;
        status_seen = '0;
        in_idle_on  = 1'b1;
        clear_text();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_texts();
        test_alignment();
        test_group_errors();
        wait_all_results();
        test_element_limits();
        test_random_layouts();

        wait_all_results();
        repeat (20) @(posedge clk);

        $display("tb: %0d characters in %0d texts, %0d element and %0d status beats",
                 chars_sent, texts_sent, elem_recs, final_recs);
        $display("tb: status codes reached (code 8 down to 0): %b", status_seen);
        if (failures == 0 && expected_recs.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
